/* sv/cdq_pkg.sv */
// Package with the word types, action codes and sizes of the circular deque.
package cdq_pkg;

	localparam int MAX_SLOTS = 16;
	localparam int IDX_W = $clog2(MAX_SLOTS);
	localparam int CAP_W = IDX_W + 1;
	localparam int CFG_W = 5;
	localparam int ITEM_W = 32;

	localparam logic [2:0] ACT_NONE = 3'd0;
	localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
	localparam logic [2:0] ACT_PUSH_REAR = 3'd2;
	localparam logic [2:0] ACT_POP_FRONT = 3'd3;
	localparam logic [2:0] ACT_POP_REAR = 3'd4;

	typedef struct packed {
		logic [2:0] action;
		logic signed [ITEM_W-1:0] item_value;
	} cmd_word_t;

	typedef struct packed {
		logic rejected;
		logic signed [ITEM_W-1:0] front_item;
		logic signed [ITEM_W-1:0] rear_item;
		logic is_empty;
		logic is_full;
	} res_word_t;

	typedef struct packed {
		logic take;
		logic exec;
		logic read;
		logic load;
	} dp_cmd_t;

endpackage

/* sv/cdq_ctrl.sv */
// Controller state machine that sequences one word through the deque datapath.
module cdq_ctrl import cdq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	output logic res_valid,
	input  logic res_stall,
	output dp_cmd_t dp_cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_LOAD = 2'd3;

	logic [1:0] state_q;
	logic res_valid_q;
	logic load_ok;

	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign load_ok = !res_valid_q || !res_stall;

	always_comb begin
		dp_cmd.take = (state_q == ST_IDLE) && cmd_valid;
		dp_cmd.exec = (state_q == ST_EXEC);
		dp_cmd.read = (state_q == ST_READ);
		dp_cmd.load = (state_q == ST_LOAD) && load_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (dp_cmd.load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (load_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/cdq_datapath.sv */
// Datapath of the circular deque: ring store, end indices, flags and result register.
module cdq_datapath import cdq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  dp_cmd_t dp_cmd,
	input  cmd_word_t cmd_word,
	input  logic cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	output res_word_t res_word
);

	logic [ITEM_W-1:0] mem [MAX_SLOTS];

	logic [2:0] act_q;
	logic [ITEM_W-1:0] item_q;
	logic [CAP_W-1:0] cap_q;
	logic [IDX_W-1:0] front_q;
	logic [IDX_W-1:0] rear_q;
	logic empty_q;
	logic rejected_q;
	logic [ITEM_W-1:0] front_rd_q;
	logic [ITEM_W-1:0] rear_rd_q;
	res_word_t res_q;

	logic [IDX_W-1:0] front_d;
	logic [IDX_W-1:0] rear_d;
	logic empty_d;
	logic rejected_d;
	logic wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic full_now;
	logic [CAP_W-1:0] cap_cfg;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i,
		input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] inc;
		inc = {1'b0, i} + CAP_W'(1);
		return (inc >= cap) ? '0 : inc[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i,
		input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] dec;
		dec = cap - CAP_W'(1);
		return (i == '0) ? dec[IDX_W-1:0] : i - IDX_W'(1);
	endfunction

	assign full_now = !empty_q && (front_q == ring_next(rear_q, cap_q));

	always_comb begin
		if (32'(cfg_data) > 32'(MAX_SLOTS)) begin
			cap_cfg = CAP_W'(MAX_SLOTS);
		end else if (cfg_data == '0) begin
			cap_cfg = CAP_W'(1);
		end else begin
			cap_cfg = CAP_W'(cfg_data);
		end
	end

	always_comb begin
		front_d = front_q;
		rear_d = rear_q;
		empty_d = empty_q;
		rejected_d = 1'b0;
		wr_en = 1'b0;
		wr_idx = rear_q;
		unique case (act_q)
			ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
				if (full_now) begin
					rejected_d = 1'b1;
				end else begin
					wr_en = 1'b1;
					if (empty_q) begin
						front_d = '0;
						rear_d = '0;
						empty_d = 1'b0;
					end else if (act_q == ACT_PUSH_FRONT) begin
						front_d = ring_prev(front_q, cap_q);
					end else begin
						rear_d = ring_next(rear_q, cap_q);
					end
					wr_idx = (act_q == ACT_PUSH_FRONT) ? front_d : rear_d;
				end
			end
			ACT_POP_FRONT, ACT_POP_REAR: begin
				if (empty_q) begin
					rejected_d = 1'b1;
				end else if (front_q == rear_q) begin
					front_d = '0;
					rear_d = '0;
					empty_d = 1'b1;
				end else if (act_q == ACT_POP_FRONT) begin
					front_d = ring_next(front_q, cap_q);
				end else begin
					rear_d = ring_prev(rear_q, cap_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.take) begin
			act_q <= cmd_word.action;
			item_q <= cmd_word.item_value;
		end
		if (dp_cmd.exec && wr_en) begin
			mem[wr_idx] <= item_q;
		end
		if (dp_cmd.read) begin
			front_rd_q <= mem[front_q];
			rear_rd_q <= mem[rear_q];
		end
		if (dp_cmd.exec) begin
			rejected_q <= rejected_d;
		end
		if (dp_cmd.load) begin
			res_q.rejected <= rejected_q;
			res_q.front_item <= empty_q ? '1 : front_rd_q;
			res_q.rear_item <= empty_q ? '1 : rear_rd_q;
			res_q.is_empty <= empty_q;
			res_q.is_full <= full_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(MAX_SLOTS);
			front_q <= '0;
			rear_q <= '0;
			empty_q <= 1'b1;
		end else if (cfg_we) begin
			cap_q <= cap_cfg;
			front_q <= '0;
			rear_q <= '0;
			empty_q <= 1'b1;
		end else if (dp_cmd.exec) begin
			front_q <= front_d;
			rear_q <= rear_d;
			empty_q <= empty_d;
		end
	end

	assign res_word = res_q;

endmodule

/* sv/circular_deque_top.sv */
// Top level of the circular deque: controller and datapath joined by commands.
// A word is accepted only while the controller is idle. The execute state then updates the
// indices and writes the ring store, the read state reads the store into registers and the
// load state loads the result register, and no new word is accepted until the controller
// is back in idle. A new word is taken while the previous result still waits in the
// output register; it then holds in the load state until that result has been taken.
// Reset empties the deque and sets the capacity to the full ring; store contents are kept.
module circular_deque_top import cdq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_word_t cmd_word,
	output logic res_valid,
	input  logic res_stall,
	output res_word_t res_word,
	input  logic cfg_we,
	input  logic [CFG_W-1:0] cfg_data
);

	dp_cmd_t dp_cmd;

	cdq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.dp_cmd(dp_cmd)
	);

	cdq_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.dp_cmd(dp_cmd),
		.cmd_word(cmd_word),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.res_word(res_word)
	);

endmodule

/* tb/circular_deque_top_tb.sv */
// Self-checking testbench for the circular deque: random and directed words against a predictor.
module circular_deque_top_tb;
	import cdq_pkg::*;

	localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0] ACT_SPARE_MID = 3'd6;
	localparam logic [2:0] ACT_SPARE_LAST = 3'd7;
	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_WORDS = 130;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_word_t cmd_word = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_word_t res_word;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;

	cmd_word_t pending_words[$];
	res_word_t expected_results[$];

	logic signed [ITEM_W-1:0] ring_copy[MAX_SLOTS];
	int front_pos = 0;
	int rear_pos = 0;
	bit deque_empty = 1'b1;
	logic [CFG_W-1:0] capacity_reg = CFG_W'(MAX_SLOTS);

	bit calm = 1'b0;
	bit want_hold = 1'b0;
	bit hold_started = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int cycles = 0;
	int failures = 0;
	int words_sent = 0;
	int results_seen = 0;
	int rejected_seen = 0;
	int full_seen = 0;
	int settings_used = 1;

	circular_deque_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_word(cmd_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word(res_word),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int ring_after(int i, int slots);
		return (i + 1 >= slots) ? 0 : i + 1;
	endfunction

	function automatic int ring_before(int i, int slots);
		return (i == 0) ? slots - 1 : i - 1;
	endfunction

	function automatic int slots_in_use();
		if (capacity_reg == 0)
			return 1;
		if (capacity_reg > MAX_SLOTS)
			return MAX_SLOTS;
		return int'(capacity_reg);
	endfunction

	function automatic res_word_t deque_apply(cmd_word_t w);
		res_word_t r;
		int slots;
		slots = slots_in_use();
		r = '0;
		if (w.action == ACT_PUSH_FRONT || w.action == ACT_PUSH_REAR) begin
			if (!deque_empty && front_pos == ring_after(rear_pos, slots)) begin
				r.rejected = 1'b1;
			end else begin
				if (deque_empty) begin
					front_pos = 0;
					rear_pos = 0;
					deque_empty = 1'b0;
				end else if (w.action == ACT_PUSH_FRONT) begin
					front_pos = ring_before(front_pos, slots);
				end else begin
					rear_pos = ring_after(rear_pos, slots);
				end
				if (w.action == ACT_PUSH_FRONT)
					ring_copy[front_pos] = w.item_value;
				else
					ring_copy[rear_pos] = w.item_value;
			end
		end else if (w.action == ACT_POP_FRONT || w.action == ACT_POP_REAR) begin
			if (deque_empty) begin
				r.rejected = 1'b1;
			end else if (front_pos == rear_pos) begin
				front_pos = 0;
				rear_pos = 0;
				deque_empty = 1'b1;
			end else if (w.action == ACT_POP_FRONT) begin
				front_pos = ring_after(front_pos, slots);
			end else begin
				rear_pos = ring_before(rear_pos, slots);
			end
		end
		r.is_empty = deque_empty;
		r.front_item = deque_empty ? -32'sd1 : ring_copy[front_pos];
		r.rear_item = deque_empty ? -32'sd1 : ring_copy[rear_pos];
		r.is_full = !deque_empty && front_pos == ring_after(rear_pos, slots);
		return r;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				expected_results.push_back(deque_apply(cmd_word));
				words_sent++;
			end
			if (!cmd_valid || !cmd_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_valid <= 1'b0;
				end else if (pending_words.size() == 0) begin
					cmd_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 9) == 0) begin
					gap_left = $urandom_range(1, 14) - 1;
					cmd_valid <= 1'b0;
				end else begin
					cmd_word <= pending_words.pop_front();
					cmd_valid <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (want_hold && !hold_started) begin
			hold_started = 1'b1;
			stall_left = LONG_HOLD;
		end
		if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		res_word_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				$error("result word arrived with nothing expected");
				failures++;
			end else begin
				want = expected_results.pop_front();
				results_seen++;
				if (want.rejected)
					rejected_seen++;
				if (want.is_full)
					full_seen++;
				if (res_word.rejected !== want.rejected) begin
					$error("rejected: expected %0d, got %0d", want.rejected, res_word.rejected);
					failures++;
				end
				if (res_word.front_item !== want.front_item) begin
					$error("front_item: expected %0d, got %0d", want.front_item,
						res_word.front_item);
					failures++;
				end
				if (res_word.rear_item !== want.rear_item) begin
					$error("rear_item: expected %0d, got %0d", want.rear_item,
						res_word.rear_item);
					failures++;
				end
				if (res_word.is_empty !== want.is_empty) begin
					$error("is_empty: expected %0d, got %0d", want.is_empty, res_word.is_empty);
					failures++;
				end
				if (res_word.is_full !== want.is_full) begin
					$error("is_full: expected %0d, got %0d", want.is_full, res_word.is_full);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || cmd_valid || expected_results.size() != 0);
	endtask

	task automatic set_capacity(input logic [CFG_W-1:0] value);
		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity_reg = value;
		front_pos = 0;
		rear_pos = 0;
		deque_empty = 1'b1;
		settings_used++;
		@(negedge clk);
	endtask

	task automatic queue_word(input logic [2:0] act, input logic signed [ITEM_W-1:0] value);
		cmd_word_t w;
		w.action = act;
		w.item_value = value;
		pending_words.push_back(w);
	endtask

	function automatic cmd_word_t random_word(bit filling);
		cmd_word_t w;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			w.action = ACT_NONE;
		else if (pick < 8)
			w.action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
		else if (pick < (filling ? 70 : 30))
			w.action = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
		else
			w.action = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR;
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: w.item_value = 32'sd0;
				1: w.item_value = -32'sd1;
				2: w.item_value = 32'sh8000_0000;
				default: w.item_value = 32'sh7fff_ffff;
			endcase
		end else begin
			w.item_value = $urandom;
		end
		return w;
	endfunction

	task automatic queue_random(input int count);
		int chunk;
		bit filling;
		chunk = 0;
		filling = 1'b1;
		for (int i = 0; i < count; i++) begin
			if (chunk == 0) begin
				chunk = $urandom_range(8, 48);
				filling = $urandom_range(0, 1);
			end
			chunk--;
			pending_words.push_back(random_word(filling));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Full ring after reset: rejects on empty, spare codes, wrap at the front.
		queue_word(ACT_POP_FRONT, 32'sd5);
		queue_word(ACT_POP_REAR, 32'sd6);
		queue_word(ACT_NONE, -32'sd1);
		queue_word(ACT_SPARE_FIRST, 32'sh7fff_ffff);
		queue_word(ACT_SPARE_MID, 32'sh8000_0000);
		queue_word(ACT_SPARE_LAST, 32'sd0);
		queue_word(ACT_PUSH_FRONT, 32'sh7fff_ffff);
		queue_word(ACT_PUSH_REAR, 32'sh8000_0000);
		queue_word(ACT_PUSH_FRONT, -32'sd1);
		queue_word(ACT_PUSH_REAR, 32'sd0);
		queue_word(ACT_SPARE_LAST, 32'sd1);
		queue_word(ACT_POP_FRONT, 32'sd0);
		queue_word(ACT_POP_REAR, 32'sd0);
		queue_word(ACT_POP_FRONT, 32'sd0);
		queue_word(ACT_POP_REAR, 32'sd0);
		queue_word(ACT_POP_REAR, 32'sd0);

		// A single slot fills at once and rejects further pushes.
		set_capacity(CFG_W'(1));
		queue_word(ACT_PUSH_REAR, 32'sh5555_5555);
		queue_word(ACT_PUSH_FRONT, 32'shaaaa_aaaa);
		queue_word(ACT_PUSH_REAR, 32'sd7);
		queue_word(ACT_POP_REAR, 32'sd0);
		queue_word(ACT_PUSH_FRONT, 32'sh1234_5678);
		queue_word(ACT_POP_FRONT, 32'sd0);

		// A capacity of zero behaves as one slot.
		set_capacity(CFG_W'(0));
		queue_word(ACT_PUSH_FRONT, 32'sh0f0f_0f0f);
		queue_word(ACT_PUSH_REAR, 32'shf0f0_f0f0);
		queue_word(ACT_POP_FRONT, 32'sd0);

		// The output is held off for a long stretch while words keep coming.
		set_capacity(CFG_W'(MAX_SLOTS));
		want_hold = 1'b1;
		queue_random(PHASE_WORDS);
		set_capacity(CFG_W'(1));
		queue_random(PHASE_WORDS);
		set_capacity(CFG_W'(31));
		queue_random(PHASE_WORDS);
		set_capacity(CFG_W'(2));
		queue_random(PHASE_WORDS);
		set_capacity(CFG_W'($urandom_range(3, 15)));
		queue_random(PHASE_WORDS);
		set_capacity(CFG_W'(17));
		queue_random(PHASE_WORDS);
		set_capacity(CFG_W'($urandom_range(0, 31)));
		queue_random(PHASE_WORDS);
		set_capacity(CFG_W'(MAX_SLOTS));
		calm = 1'b1;
		queue_random(PHASE_WORDS);

		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Sent %0d words across %0d capacity settings and checked %0d results.",
			words_sent, settings_used, results_seen);
		$display("Of those, %0d actions were rejected and %0d results showed a full deque.",
			rejected_seen, full_seen);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* circular_deque_top.f */
sv/cdq_pkg.sv
sv/cdq_ctrl.sv
sv/cdq_datapath.sv
sv/circular_deque_top.sv
tb/circular_deque_top_tb.sv
